@@ hdl/look_elevator_scheduler_assert.svh @@
// Assertion macros for the checker file of the elevator scheduler.
`ifndef LOOK_ELEVATOR_SCHEDULER_ASSERT_SVH
`define LOOK_ELEVATOR_SCHEDULER_ASSERT_SVH

// Property checked on every rising edge, suspended while reset is asserted.
`define LES_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("scheduler assertion failed");

// Property checked on every rising edge, reset included.
`define LES_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("scheduler reset assertion failed");

`endif

@@ hdl/les_pkg.sv @@
// Shared constants, codes and payload types of the elevator scheduler.
package les_pkg;

    // Widths of the request and response fields.
    localparam int FLOOR_W  = 8;
    localparam int OPCODE_W = 2;

    // Bitmap spans every position the floor field can name.
    localparam int MAP_SIZE = 2 ** FLOOR_W;

    // Number of floors served; positions at or above the limit are ignored.
    localparam int FLOORS      = 256;
    localparam int FLOOR_LIMIT = (FLOORS < MAP_SIZE) ? FLOORS : MAP_SIZE;

    // Request operations.
    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD    = 2'd0,
        OP_CANCEL = 2'd1,
        OP_SERVE  = 2'd2
    } t_opcode;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [FLOOR_W-1:0]  floor;
    } t_req;

    typedef struct packed {
        logic [FLOOR_W-1:0] current_floor;
        logic               heading_up;
        logic               served;
    } t_rsp;

endpackage

@@ hdl/les_if.sv @@
// Valid/ready stream interfaces for scheduler requests and responses.
interface les_req_if;
    import les_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface les_rsp_if;
    import les_pkg::*;

    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/look_elevator_scheduler.sv @@
// LOOK elevator request scheduler. Each request (add, cancel or serve a floor)
// produces exactly one response carrying the current floor, the direction and
// a served flag, in request order. The block sustains one request per clock
// cycle while the response side is ready. A request is held in the input
// register, and its response is then held in the response register. The cycle
// time is set by the two 256-bit priority encoders that search the pending
// bitmap above and below the current floor. Reset clears the bitmap, sets the
// floor to 0 and the direction to up; requests are taken as soon as reset is
// released. Backpressure on the response side stalls the request side only
// once both internal registers are full.
module look_elevator_scheduler (
    input  logic             i_clk,
    input  logic             i_rst_n,
    les_req_if.sink          i_req,
    les_rsp_if.source        o_rsp
);
    import les_pkg::*;

    logic r_in_valid;
    t_req r_req;
    logic r_out_valid;
    t_rsp r_rsp;

    t_rsp n_rsp;
    logic w_fire;

    // The held request is processed when the response register can take it.
    assign w_fire      = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || w_fire;

    les_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_req   (r_req),
        .o_next  (n_rsp)
    );

    // Valid flags of the input and response registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers load on a request transfer or on processing.
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req <= i_req.data;
        end
        if (w_fire) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_rsp;
endmodule

@@ hdl/les_lowbit.sv @@
// Priority encoder that finds the lowest set bit of the pending bitmap.
module les_lowbit (
    input  logic [les_pkg::MAP_SIZE-1:0] i_vec,
    output logic                         o_found,
    output logic [les_pkg::FLOOR_W-1:0]  o_idx
);
    import les_pkg::*;

    logic [MAP_SIZE-1:0] w_low;

    // Isolate the lowest set bit with a two's complement mask.
    assign w_low   = i_vec & (~i_vec + MAP_SIZE'(1));
    assign o_found = |i_vec;

    // Convert the one-hot bit to its index.
    always_comb begin
        o_idx = '0;
        for (int i = 0; i < MAP_SIZE; i++) begin
            if (w_low[i]) begin
                o_idx = o_idx | FLOOR_W'(i);
            end
        end
    end
endmodule

@@ hdl/les_core.sv @@
// Scheduler state: pending bitmap, position and direction, with next-state logic.
module les_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  les_pkg::t_req i_req,
    output les_pkg::t_rsp o_next
);
    import les_pkg::*;

    logic [MAP_SIZE-1:0] r_pending;
    logic [FLOOR_W-1:0]  r_pos;
    logic                r_heading_up;

    logic [MAP_SIZE-1:0] n_pending;
    logic [FLOOR_W-1:0]  n_pos;
    logic                n_heading_up;
    logic                n_served;

    logic [MAP_SIZE-1:0] w_above_vec;
    logic [MAP_SIZE-1:0] w_below_vec;
    logic [MAP_SIZE-1:0] w_below_rev;
    logic                w_above_found;
    logic                w_below_found;
    logic [FLOOR_W-1:0]  w_above_idx;
    logic [FLOOR_W-1:0]  w_below_rev_idx;
    logic [FLOOR_W-1:0]  w_below_idx;
    logic                w_in_range;

    // Pending positions strictly above and strictly below the current one.
    assign w_above_vec = r_pending & (({MAP_SIZE{1'b1}} << r_pos) << 1);
    assign w_below_vec = r_pending & ~({MAP_SIZE{1'b1}} << r_pos);

    // Mirror the lower half so the nearest one below becomes the lowest set bit.
    always_comb begin
        for (int i = 0; i < MAP_SIZE; i++) begin
            w_below_rev[i] = w_below_vec[MAP_SIZE-1-i];
        end
    end

    les_lowbit u_above (
        .i_vec   (w_above_vec),
        .o_found (w_above_found),
        .o_idx   (w_above_idx)
    );

    les_lowbit u_below (
        .i_vec   (w_below_rev),
        .o_found (w_below_found),
        .o_idx   (w_below_rev_idx)
    );

    assign w_below_idx = FLOOR_W'(MAP_SIZE - 1) - w_below_rev_idx;
    assign w_in_range  = {1'b0, i_req.floor} < (FLOOR_W + 1)'(FLOOR_LIMIT);

    // Next state for the request in the input register.
    always_comb begin
        n_pending    = r_pending;
        n_pos        = r_pos;
        n_heading_up = r_heading_up;
        n_served     = 1'b0;
        unique case (i_req.opcode)
            OP_ADD: begin
                if (w_in_range && (i_req.floor != r_pos)) begin
                    n_pending[i_req.floor] = 1'b1;
                end
            end
            OP_CANCEL: begin
                if (w_in_range) begin
                    n_pending[i_req.floor] = 1'b0;
                end
            end
            OP_SERVE: begin
                // Keep the direction while requests remain ahead, else turn around.
                if (r_heading_up) begin
                    if (w_above_found) begin
                        n_pos = w_above_idx;
                    end else if (w_below_found) begin
                        n_pos        = w_below_idx;
                        n_heading_up = 1'b0;
                    end
                end else begin
                    if (w_below_found) begin
                        n_pos = w_below_idx;
                    end else if (w_above_found) begin
                        n_pos        = w_above_idx;
                        n_heading_up = 1'b1;
                    end
                end
                if (w_above_found || w_below_found) begin
                    n_pending[n_pos] = 1'b0;
                    n_served         = 1'b1;
                end
            end
            default: begin
                n_served = 1'b0;
            end
        endcase
    end

    // State registers advance once per processed request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending    <= '0;
            r_pos        <= '0;
            r_heading_up <= 1'b1;
        end else if (i_fire) begin
            r_pending    <= n_pending;
            r_pos        <= n_pos;
            r_heading_up <= n_heading_up;
        end
    end

    assign o_next.current_floor = n_pos;
    assign o_next.heading_up    = n_heading_up;
    assign o_next.served        = n_served;
endmodule

@@ hdl/les_checker.sv @@
// Port-level checker for the elevator scheduler, bound to the top level.
`include "look_elevator_scheduler_assert.svh"

module les_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_rsp_valid,
    input logic                        i_rsp_ready,
    input logic [les_pkg::FLOOR_W-1:0] i_rsp_current_floor,
    input logic                        i_rsp_heading_up,
    input logic                        i_rsp_served
);
    import les_pkg::*;

    logic w_xfer;

    assign w_xfer = i_rsp_valid && i_rsp_ready;

    // Reset empties the response register.
    `LES_ASSERT_ALWAYS(a_reset_clears_rsp, i_clk, !i_rst_n |=> !i_rsp_valid)

    // A stalled response stays offered and unchanged.
    `LES_ASSERT(a_rsp_hold, i_clk, i_rst_n, (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_current_floor) && $stable(i_rsp_heading_up) && $stable(i_rsp_served)))

    // Back-to-back responses: a request that serves nothing moves nothing.
    `LES_ASSERT(a_idle_keeps_pos, i_clk, i_rst_n, w_xfer ##1 (w_xfer && !i_rsp_served) |-> (i_rsp_current_floor == $past(i_rsp_current_floor) && i_rsp_heading_up == $past(i_rsp_heading_up)))

    // Back-to-back responses: a serve always leaves the current floor.
    `LES_ASSERT(a_serve_moves, i_clk, i_rst_n, w_xfer ##1 (w_xfer && i_rsp_served) |-> (i_rsp_current_floor != $past(i_rsp_current_floor)))
endmodule

bind look_elevator_scheduler les_checker u_les_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_rsp_valid         (o_rsp.valid),
    .i_rsp_ready         (o_rsp.ready),
    .i_rsp_current_floor (o_rsp.data.current_floor),
    .i_rsp_heading_up    (o_rsp.data.heading_up),
    .i_rsp_served        (o_rsp.data.served)
);
